@@ design/abpm_pkg.sv @@
// Shared types and constants for the adaptive bit probability model.
package abpm_pkg;

    localparam int BUCKET_W = 8;
    localparam int COUNT_W  = 16;
    localparam int PROB_W   = 16;
    localparam int ENTRY_W  = 2 * COUNT_W;

    localparam int DIV_STEPS = PROB_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    typedef logic [BUCKET_W-1:0] bucket_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [PROB_W-1:0]   prob_t;
    typedef logic [ENTRY_W-1:0]  entry_t;

    localparam count_t ZERO_RESET    = 16'h0001;
    localparam count_t TOTAL_RESET   = 16'h0002;
    localparam count_t RESCALE_LIMIT = 16'hFFFF;
    localparam count_t ZERO_FLOOR    = 16'h0001;
    localparam count_t TOTAL_FLOOR   = 16'h0003;

endpackage

@@ design/abpm_in_if.sv @@
// Request channel: bucket index and coded bit.
interface abpm_in_if;
    import abpm_pkg::*;

    logic    valid;
    logic    ready;
    bucket_t bucket_index;
    logic    bit_value;

    modport source (output valid, output bucket_index, output bit_value, input ready);
    modport sink   (input valid, input bucket_index, input bit_value, output ready);
endinterface

@@ design/abpm_out_if.sv @@
// Result channel: zero probability and rescale flag.
interface abpm_out_if;
    import abpm_pkg::*;

    logic  valid;
    logic  ready;
    prob_t zero_probability;
    logic  rescaled;

    modport source (output valid, output zero_probability, output rescaled, input ready);
    modport sink   (input valid, input zero_probability, input rescaled, output ready);
endinterface

@@ design/abpm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module abpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/abpm_divider.sv @@
// Iterative restoring divider: low quotient bits of (zeros << 16) / total.
module abpm_divider (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  abpm_pkg::count_t dividend,
    input  abpm_pkg::count_t divisor,
    output logic            done,
    output abpm_pkg::prob_t quotient
);
    import abpm_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    count_t            rem_reg;
    count_t            div_reg;
    prob_t             quot_reg;

    logic [COUNT_W:0] trial;
    logic [COUNT_W:0] diff;
    logic             fits;

    assign trial = {rem_reg, 1'b0};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (divisor == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    step_reg <= STEP_W'(DIV_STEPS);
                end
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Reduce the dividend modulo the divisor once, then shift in one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg  <= divisor;
            quot_reg <= (divisor == '0) ? '1 : '0;
            rem_reg  <= (dividend >= divisor) ? (dividend - divisor) : dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            quot_reg <= {quot_reg[PROB_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

@@ design/adaptive_bit_probability_model.sv @@
// Adaptive bit probability model: per-bucket zero and total counts, probability out, update.
//
// Each transfer on the request channel names a bucket and the bit coded with it. The block
// returns the probability of a zero, (zeros << 16) / total truncated to 16 bits, taken before
// the counts are updated, together with a flag that is set when the update halved the counts.
// An in-range request reads its bucket from the RAM, runs the sixteen steps of the restoring
// divider and writes the updated counts back; an index at or above BUCKET_COUNT returns zero
// and leaves the counts alone.
// One request is in work at a time; the next is accepted while an earlier result still waits
// in the output register. Buckets come out of reset with counts 1 and 2 and need no clearing
// pass.
module adaptive_bit_probability_model #(
    parameter int BUCKET_COUNT = 256
) (
    input logic        clk,
    input logic        rst_n,
    abpm_in_if.sink    request,
    abpm_out_if.source result
);
    import abpm_pkg::*;

    localparam int DEPTH  = (BUCKET_COUNT < (1 << BUCKET_W)) ? BUCKET_COUNT : (1 << BUCKET_W);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              out_valid_reg;

    logic [ADDR_W-1:0] idx_reg;
    logic              bit_reg;
    logic              in_range_reg;
    count_t            zero_reg;
    count_t            total_reg;
    prob_t             prob_reg;
    logic              resc_reg;
    prob_t             out_prob_reg;
    logic              out_resc_reg;

    logic   accept;
    logic   in_range;
    entry_t rd_data;
    logic   entry_valid;
    count_t zero_cur;
    count_t total_cur;
    logic   div_start;
    logic   div_done;
    prob_t  quotient;
    count_t zero_inc;
    count_t total_inc;
    logic   rescale;
    count_t zero_new;
    count_t total_new;
    logic   wr_en;
    logic   out_free;

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign in_range      = (32'(request.bucket_index) < BUCKET_COUNT);
    assign out_free      = !out_valid_reg || result.ready;

    assign entry_valid = valid_reg[idx_reg];
    assign zero_cur    = entry_valid ? rd_data[ENTRY_W-1:COUNT_W] : ZERO_RESET;
    assign total_cur   = entry_valid ? rd_data[COUNT_W-1:0] : TOTAL_RESET;
    assign div_start   = (state_reg == S_LOAD) && in_range_reg;

    assign zero_inc  = bit_reg ? zero_reg : (zero_reg + COUNT_W'(1));
    assign total_inc = total_reg + COUNT_W'(1);
    assign rescale   = (total_inc >= RESCALE_LIMIT);
    assign zero_new  = rescale ? ((zero_inc >> 1) | ZERO_FLOOR) : zero_inc;
    assign total_new = rescale ? ((total_inc >> 1) | TOTAL_FLOOR) : total_inc;
    assign wr_en     = (state_reg == S_DIV) && div_done;

    abpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data ({zero_new, total_new}),
        .rd_en   (accept),
        .rd_addr (request.bucket_index[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    abpm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (zero_cur),
        .divisor  (total_cur),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= in_range_reg ? S_DIV : S_DONE;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        state_reg          <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg      <= request.bucket_index[ADDR_W-1:0];
            bit_reg      <= request.bit_value;
            in_range_reg <= in_range;
        end
        if (state_reg == S_LOAD)
        begin
            zero_reg  <= zero_cur;
            total_reg <= total_cur;
            prob_reg  <= '0;
            resc_reg  <= 1'b0;
        end
        if (wr_en)
        begin
            prob_reg <= quotient;
            resc_reg <= rescale;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_prob_reg <= prob_reg;
            out_resc_reg <= resc_reg;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.zero_probability = out_prob_reg;
    assign result.rescaled         = out_resc_reg;

endmodule

@@ verif/tb_adaptive_bit_probability_model.sv @@
// Self-checking testbench for the adaptive bit probability model: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_adaptive_bit_probability_model;
    import abpm_pkg::*;

    localparam int          BUCKETS      = 256;
    localparam count_t      ZERO_START   = 16'h0001;
    localparam count_t      TOTAL_START  = 16'h0002;
    localparam count_t      HALVE_AT     = 16'hFFFF;
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int          TAIL_CYCLES  = 30;
    localparam int          RANDOM_ITEMS = 234;
    localparam int          PHASES       = 4;

    localparam int unsigned GAP_PCT  [PHASES] = '{0, 50, 0, 26};
    localparam int unsigned HOLD_PCT [PHASES] = '{0, 0, 50, 26};

    typedef struct packed {
        prob_t prob;
        logic  rescaled;
    } outcome_t;

    typedef struct packed {
        bucket_t     bucket;
        logic        bit_value;
        int unsigned repeats;
        logic        typed;
        prob_t       prob;
        logic        rescaled;
    } row_t;

    localparam int N_ROWS = 15;
    localparam row_t DIRECTED_ROWS [N_ROWS] = '{
        '{8'h00, 1'b0, 1,     1'b1, 16'h8000, 1'b0},
        '{8'hFF, 1'b1, 1,     1'b1, 16'h8000, 1'b0},
        '{8'h00, 1'b0, 1,     1'b0, 16'h0000, 1'b0},
        '{8'hFF, 1'b1, 1,     1'b0, 16'h0000, 1'b0},
        '{8'h00, 1'b1, 1,     1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b1, 1,     1'b1, 16'h8000, 1'b0},
        '{8'h80, 1'b1, 1,     1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b1, 1,     1'b0, 16'h0000, 1'b0},
        '{8'h01, 1'b0, 1,     1'b1, 16'h8000, 1'b0},
        '{8'h7F, 1'b0, 1,     1'b1, 16'h8000, 1'b0},
        '{8'h55, 1'b1, 1,     1'b1, 16'h8000, 1'b0},
        '{8'hAA, 1'b0, 1,     1'b1, 16'h8000, 1'b0},
        '{8'hA5, 1'b0, 1,     1'b0, 16'h0000, 1'b0},
        '{8'hA5, 1'b1, 1,     1'b0, 16'h0000, 1'b0},
        '{8'hFF, 1'b0, 1,     1'b0, 16'h0000, 1'b0}
    };

    localparam bucket_t HOT_BUCKETS [4] = '{8'h03, 8'h5C, 8'hA5, 8'hFE};

    logic clk;
    logic rst_n;

    abpm_in_if  request_bus ();
    abpm_out_if result_bus ();

    adaptive_bit_probability_model #(
        .BUCKET_COUNT (BUCKETS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_bus),
        .result  (result_bus)
    );

    count_t      zero_tally  [BUCKETS];
    count_t      total_tally [BUCKETS];
    outcome_t    probability_q [$];
    int unsigned fault_count;
    int unsigned gap_pct;
    int unsigned hold_pct;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic outcome_t predict_probability(input bucket_t b, input logic bv);
        outcome_t    o;
        count_t      z;
        count_t      t;
        logic [31:0] quotient;
        o = '0;
        if (int'(b) >= BUCKETS)
            return o;
        z = zero_tally[b];
        t = total_tally[b];
        if (t == '0)
            o.prob = 16'hFFFF;
        else
        begin
            quotient = {z, 16'h0000} / {16'h0000, t};
            o.prob   = quotient[15:0];
        end
        if (!bv)
            z = z + 16'd1;
        t = t + 16'd1;
        if (t >= HALVE_AT)
        begin
            o.rescaled = 1'b1;
            z = (z >> 1) | 16'h0001;
            t = (t >> 1) | 16'h0003;
        end
        zero_tally[b]  = z;
        total_tally[b] = t;
        return o;
    endfunction

    task automatic send_item(input bucket_t b, input logic bv, input logic typed,
                             input prob_t tprob, input logic tresc);
        outcome_t o;
        while ($urandom_range(99) < gap_pct)
        begin
            request_bus.valid <= 1'b0;
            @(posedge clk);
        end
        request_bus.valid        <= 1'b1;
        request_bus.bucket_index <= b;
        request_bus.bit_value    <= bv;
        do
            @(posedge clk);
        while (!request_bus.ready);
        o = predict_probability(b, bv);
        if (typed)
        begin
            o.prob     = tprob;
            o.rescaled = tresc;
        end
        probability_q.push_back(o);
    endtask

    task automatic drain_results();
        request_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (probability_q.size() != 0);
    endtask

    // result side: stall, compare each transfer with the oldest expectation
    initial
    begin
        outcome_t want;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                if (probability_q.size() == 0)
                begin
                    $error("zero_probability: no transfer expected, got %0d",
                           result_bus.zero_probability);
                    fault_count++;
                end
                else
                begin
                    want = probability_q.pop_front();
                    if (result_bus.zero_probability !== want.prob)
                    begin
                        $error("zero_probability: expected %0d, got %0d",
                               want.prob, result_bus.zero_probability);
                        fault_count++;
                    end
                    if (result_bus.rescaled !== want.rescaled)
                    begin
                        $error("rescaled: expected %0d, got %0d",
                               want.rescaled, result_bus.rescaled);
                        fault_count++;
                    end
                end
            end
            result_bus.ready <= ($urandom_range(99) >= hold_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        bucket_t b;
        logic    bv;
        fault_count = 0;
        gap_pct     = 0;
        hold_pct    = 0;
        for (int i = 0; i < BUCKETS; i++)
        begin
            zero_tally[i]  = ZERO_START;
            total_tally[i] = TOTAL_START;
        end
        rst_n                    <= 1'b0;
        request_bus.valid        <= 1'b0;
        request_bus.bucket_index <= '0;
        request_bus.bit_value    <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
            repeat (DIRECTED_ROWS[r].repeats)
                send_item(DIRECTED_ROWS[r].bucket, DIRECTED_ROWS[r].bit_value,
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].prob,
                          DIRECTED_ROWS[r].rescaled);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            gap_pct  = GAP_PCT[p];
            hold_pct = HOLD_PCT[p];
            repeat (RANDOM_ITEMS)
            begin
                // skew hot buckets towards zeros, spread the rest over all indexes
                if ($urandom_range(1) == 0)
                begin
                    b  = HOT_BUCKETS[$urandom_range(3)];
                    bv = ($urandom_range(3) == 0);
                end
                else
                begin
                    b  = bucket_t'($urandom_range(BUCKETS - 1));
                    bv = 1'($urandom_range(1));
                end
                send_item(b, bv, 1'b0, '0, 1'b0);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
